>>> hdl/dmpb_pkg.sv
package dmpb_pkg;

    localparam int COLOR_W        = 32;
    localparam int DEPTH_W        = 32;
    localparam int DEPTH_BITS_DEF = 32;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = COLOR_W / CHAN_W;
    localparam int ALPHA_LSB      = 24;
    localparam logic [CHAN_W-1:0] ALPHA_MAX  = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_ZERO = 8'h00;

    typedef enum logic {
        MODE_TRANSFER = 1'b0,
        MODE_SCULPT   = 1'b1
    } t_mode;

    // Where the new depth comes from.
    typedef enum logic [1:0] {
        DSEL_DST = 2'd0,
        DSEL_SRC = 2'd1,
        DSEL_SUM = 2'd2
    } t_dsel;

    typedef struct packed {
        logic  valid;
        logic  changed;
        logic  take_top;
        logic  out_inf;
        t_dsel dsel;
    } t_ctl;

endpackage

>>> hdl/dmpb_decide.sv
module dmpb_decide
    import dmpb_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req,
    input  t_mode                 i_mode,
    input  logic [COLOR_W-1:0]    i_src_color,
    input  logic [DEPTH_W-1:0]    i_src_depth,
    input  logic                  i_src_depth_infinite,
    input  logic [COLOR_W-1:0]    i_dst_color,
    input  logic [DEPTH_W-1:0]    i_dst_depth,
    input  logic                  i_dst_depth_infinite,
    output t_ctl                  o_ctl,
    output logic [COLOR_W-1:0]    o_top,
    output logic [COLOR_W-1:0]    o_bottom,
    output logic [CHAN_W-1:0]     o_inv,
    output logic [DEPTH_BITS-1:0] o_sd,
    output logic [DEPTH_BITS-1:0] o_dd
);

    logic                  r_vld;
    t_mode                 r_mode;
    logic [COLOR_W-1:0]    r_sc;
    logic [COLOR_W-1:0]    r_dc;
    logic [DEPTH_BITS-1:0] r_sd;
    logic [DEPTH_BITS-1:0] r_dd;
    logic                  r_sinf;
    logic                  r_dinf;

    logic [DEPTH_BITS-1:0] n_sd;
    logic [DEPTH_BITS-1:0] n_dd;

    // The depth ports are two's complement in their low DEPTH_BITS bits.
    generate
        if (DEPTH_BITS <= DEPTH_W) begin : g_narrow
            assign n_sd = i_src_depth[DEPTH_BITS-1:0];
            assign n_dd = i_dst_depth[DEPTH_BITS-1:0];
        end else begin : g_wide
            assign n_sd = {{(DEPTH_BITS-DEPTH_W){1'b0}}, i_src_depth};
            assign n_dd = {{(DEPTH_BITS-DEPTH_W){1'b0}}, i_dst_depth};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_req;
        end
        r_mode <= i_mode;
        r_sc   <= i_src_color;
        r_dc   <= i_dst_color;
        r_sd   <= n_sd;
        r_dd   <= n_dd;
        r_sinf <= i_src_depth_infinite;
        r_dinf <= i_dst_depth_infinite;
    end

    logic [CHAN_W-1:0]  s_sa;
    logic [CHAN_W-1:0]  s_da;
    logic               s_src_ok;
    logic               s_src_wins;
    t_ctl               n_ctl;
    logic [COLOR_W-1:0] n_top;
    logic [COLOR_W-1:0] n_bottom;

    always_comb begin
        s_sa       = r_sc[ALPHA_LSB +: CHAN_W];
        s_da       = r_dc[ALPHA_LSB +: CHAN_W];
        s_src_ok   = (s_sa != ALPHA_ZERO) && !r_sinf;
        s_src_wins = 1'b1;
        n_ctl      = '0;
        n_ctl.valid = r_vld;
        n_ctl.dsel  = DSEL_DST;
        case (r_mode)
            MODE_TRANSFER: begin
                n_ctl.changed = s_src_ok;
                s_src_wins    = r_dinf || ($signed(r_sd) >= $signed(r_dd));
                n_ctl.dsel    = s_src_wins ? DSEL_SRC : DSEL_DST;
            end
            MODE_SCULPT: begin
                n_ctl.changed = s_src_ok && (s_da != ALPHA_ZERO) && !r_dinf;
                n_ctl.dsel    = DSEL_SUM;
            end
            default: begin
                n_ctl.changed = 1'b0;
            end
        endcase
        // A skipped pixel is routed as the top with take_top set so the blend passes dst through.
        if (!n_ctl.changed) begin
            n_ctl.dsel = DSEL_DST;
            n_top      = r_dc;
            n_bottom   = r_sc;
        end else if (s_src_wins) begin
            n_top    = r_sc;
            n_bottom = r_dc;
        end else begin
            n_top    = r_dc;
            n_bottom = r_sc;
        end
        n_ctl.out_inf  = n_ctl.changed ? 1'b0 : r_dinf;
        n_ctl.take_top = !n_ctl.changed || (n_top[ALPHA_LSB +: CHAN_W] == ALPHA_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= n_ctl;
        end
        o_top    <= n_top;
        o_bottom <= n_bottom;
        o_inv    <= ALPHA_MAX - n_top[ALPHA_LSB +: CHAN_W];
        o_sd     <= r_sd;
        o_dd     <= r_dd;
    end

endmodule

>>> hdl/dmpb_blend.sv
module dmpb_blend
    import dmpb_pkg::*;
(
    input  logic               i_clk,
    input  logic [COLOR_W-1:0] i_top,
    input  logic [COLOR_W-1:0] i_bottom,
    input  logic [CHAN_W-1:0]  i_inv,
    input  logic               i_take_top,
    output logic [COLOR_W-1:0] o_color
);

    logic [2*CHAN_W-1:0] r_prod [NUM_CHAN];
    logic [COLOR_W-1:0]  r_top;
    logic                r_take_top;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            r_prod[i] <= i_bottom[i*CHAN_W +: CHAN_W] * i_inv;
        end
        r_top      <= i_top;
        r_take_top <= i_take_top;
    end

    logic [2*CHAN_W-1:0] s_sum [NUM_CHAN];
    logic [COLOR_W-1:0]  s_blend;

    // p / 255 is exact as (p + 1 + (p >> 8)) >> 8 for every product of two bytes.
    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            s_sum[i] = r_prod[i] + {{(2*CHAN_W-1){1'b0}}, 1'b1}
                       + (r_prod[i] >> CHAN_W);
            s_blend[i*CHAN_W +: CHAN_W] = r_top[i*CHAN_W +: CHAN_W]
                                          + s_sum[i][2*CHAN_W-1:CHAN_W];
        end
        o_color = r_take_top ? r_top : s_blend;
    end

endmodule

>>> hdl/depth_merge_premultiplied_blend.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------------
// request   | in        | start, busy            | src/dst color, depth, depth_infinite
// result    | out       | o_valid (strobe)       | out_color, out_depth, infinite, changed
// config    | in        | i_cfg_we               | i_cfg_wdata (merge_mode)
//
// One request is taken every cycle; busy stays low because the pipeline never stalls.
// Each request yields exactly one result, and the results come out in request order.
// The four register stages are input capture, compare and select, channel multiply
// with the depth sum, and the divide-by-255 with the output register.
// Synchronous active-low reset clears the valid bits and merge_mode.
module depth_merge_premultiplied_blend
    import dmpb_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic [COLOR_W-1:0] i_src_color,
    input  logic [DEPTH_W-1:0] i_src_depth,
    input  logic               i_src_depth_infinite,
    input  logic [COLOR_W-1:0] i_dst_color,
    input  logic [DEPTH_W-1:0] i_dst_depth,
    input  logic               i_dst_depth_infinite,
    output logic               o_valid,
    output logic [COLOR_W-1:0] o_out_color,
    output logic [DEPTH_W-1:0] o_out_depth,
    output logic               o_out_depth_infinite,
    output logic               o_pixel_changed
);

    t_mode r_merge_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_mode <= MODE_TRANSFER;
        end else if (i_cfg_we) begin
            r_merge_mode <= t_mode'(i_cfg_wdata);
        end
    end

    assign busy = 1'b0;

    t_ctl                  s2_ctl;
    logic [COLOR_W-1:0]    s2_top;
    logic [COLOR_W-1:0]    s2_bottom;
    logic [CHAN_W-1:0]     s2_inv;
    logic [DEPTH_BITS-1:0] s2_sd;
    logic [DEPTH_BITS-1:0] s2_dd;

    dmpb_decide #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_decide (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req               (start && !busy),
        .i_mode              (r_merge_mode),
        .i_src_color         (i_src_color),
        .i_src_depth         (i_src_depth),
        .i_src_depth_infinite(i_src_depth_infinite),
        .i_dst_color         (i_dst_color),
        .i_dst_depth         (i_dst_depth),
        .i_dst_depth_infinite(i_dst_depth_infinite),
        .o_ctl               (s2_ctl),
        .o_top               (s2_top),
        .o_bottom            (s2_bottom),
        .o_inv               (s2_inv),
        .o_sd                (s2_sd),
        .o_dd                (s2_dd)
    );

    logic [COLOR_W-1:0] s3_color;

    dmpb_blend u_blend (
        .i_clk     (i_clk),
        .i_top     (s2_top),
        .i_bottom  (s2_bottom),
        .i_inv     (s2_inv),
        .i_take_top(s2_ctl.take_top),
        .o_color   (s3_color)
    );

    // Saturating depth sum, one sign bit wider to see the overflow.
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    logic [DEPTH_BITS:0]   s_sum;
    logic [DEPTH_BITS-1:0] n_depth;

    always_comb begin
        s_sum = {s2_sd[DEPTH_BITS-1], s2_sd} + {s2_dd[DEPTH_BITS-1], s2_dd};
        case (s2_ctl.dsel)
            DSEL_SRC: n_depth = s2_sd;
            DSEL_SUM: begin
                if (s_sum[DEPTH_BITS] != s_sum[DEPTH_BITS-1]) begin
                    n_depth = s_sum[DEPTH_BITS] ? DEPTH_MIN : DEPTH_MAX;
                end else begin
                    n_depth = s_sum[DEPTH_BITS-1:0];
                end
            end
            default: n_depth = s2_dd;
        endcase
    end

    t_ctl                  r3_ctl;
    logic [DEPTH_BITS-1:0] r3_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= s2_ctl;
        end
        r3_depth <= n_depth;
    end

    logic [DEPTH_W-1:0] s3_depth_out;

    generate
        if (DEPTH_BITS >= DEPTH_W) begin : g_out_trunc
            assign s3_depth_out = r3_depth[DEPTH_W-1:0];
        end else begin : g_out_ext
            assign s3_depth_out = {{(DEPTH_W-DEPTH_BITS){1'b0}}, r3_depth};
        end
    endgenerate

    logic               r_valid;
    logic [COLOR_W-1:0] r_out_color;
    logic [DEPTH_W-1:0] r_out_depth;
    logic               r_out_inf;
    logic               r_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r3_ctl.valid;
        end
        r_out_color <= s3_color;
        r_out_depth <= s3_depth_out;
        r_out_inf   <= r3_ctl.out_inf;
        r_changed   <= r3_ctl.changed;
    end

    assign o_valid              = r_valid;
    assign o_out_color          = r_out_color;
    assign o_out_depth          = r_out_depth;
    assign o_out_depth_infinite = r_out_inf;
    assign o_pixel_changed      = r_changed;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("request did not produce a result four cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result without a matching request");

    a_changed_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_changed) |-> !o_out_depth_infinite)
        else $error("written pixel has an infinite depth");

    a_skip_passes_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pixel_changed)
        |-> (o_out_color == $past(i_dst_color, 4))
            && (o_out_depth_infinite == $past(i_dst_depth_infinite, 4)))
        else $error("skipped pixel does not repeat the destination");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dmpb_pkg::*;

    localparam int PHASE_ITEMS   = 225;
    localparam int NUM_PHASES    = 6;
    localparam int DRAIN_CYCLES  = 8;
    localparam int WATCHDOG_MAX  = 1000;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

    typedef struct packed {
        logic [COLOR_W-1:0] src_color;
        logic [DEPTH_W-1:0] src_z;
        logic               src_inf;
        logic [COLOR_W-1:0] dst_color;
        logic [DEPTH_W-1:0] dst_z;
        logic               dst_inf;
    } t_pixel_pair;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [DEPTH_W-1:0] depth;
        logic               inf;
        logic               changed;
    } t_merged_px;

    typedef struct packed {
        logic       listed;
        t_merged_px want;
    } t_listed_merge;

    typedef struct {
        t_mode       mode;
        t_pixel_pair req;
        logic        listed;
        t_merged_px  want;
    } t_blend_row;

    logic               i_clk                = 1'b0;
    logic               i_rst_n              = 1'b0;
    logic               start                = 1'b0;
    logic               i_cfg_we             = 1'b0;
    logic               i_cfg_wdata          = 1'b0;
    logic [COLOR_W-1:0] i_src_color          = '0;
    logic [DEPTH_W-1:0] i_src_depth          = '0;
    logic               i_src_depth_infinite = 1'b0;
    logic [COLOR_W-1:0] i_dst_color          = '0;
    logic [DEPTH_W-1:0] i_dst_depth          = '0;
    logic               i_dst_depth_infinite = 1'b0;
    logic               busy;
    logic               o_valid;
    logic [COLOR_W-1:0] o_out_color;
    logic [DEPTH_W-1:0] o_out_depth;
    logic               o_out_depth_infinite;
    logic               o_pixel_changed;

    t_listed_merge listed_q[$];
    t_merged_px    merge_q[$];
    t_blend_row    directed_rows[$];
    t_mode         cfg_mode     = MODE_TRANSFER;
    int            n_errors     = 0;
    int            n_accepted   = 0;
    int            n_results    = 0;
    int            n_listed     = 0;
    int            n_skipped    = 0;
    int            idle_cycles  = 0;

    depth_merge_premultiplied_blend dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_src_color          (i_src_color),
        .i_src_depth          (i_src_depth),
        .i_src_depth_infinite (i_src_depth_infinite),
        .i_dst_color          (i_dst_color),
        .i_dst_depth          (i_dst_depth),
        .i_dst_depth_infinite (i_dst_depth_infinite),
        .o_valid              (o_valid),
        .o_out_color          (o_out_color),
        .o_out_depth          (o_out_depth),
        .o_out_depth_infinite (o_out_depth_infinite),
        .o_pixel_changed      (o_pixel_changed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [COLOR_W-1:0] blend_over_px(input logic [COLOR_W-1:0] top,
                                                         input logic [COLOR_W-1:0] bottom);
        logic [CHAN_W-1:0] top_alpha;
        logic [15:0]       scaled;
        logic [COLOR_W-1:0] mixed;
        top_alpha = top[ALPHA_LSB +: CHAN_W];
        if (top_alpha == ALPHA_MAX) begin
            return top;
        end
        mixed = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            scaled = (16'(bottom[k*CHAN_W +: CHAN_W]) * 16'(ALPHA_MAX - top_alpha))
                     / 16'(ALPHA_MAX);
            // The channel sum wraps to 8 bits on purpose.
            mixed[k*CHAN_W +: CHAN_W] = top[k*CHAN_W +: CHAN_W] + scaled[CHAN_W-1:0];
        end
        return mixed;
    endfunction

    function automatic t_merged_px predict_merge(input t_mode mode, input t_pixel_pair p);
        t_merged_px              r;
        logic signed [DEPTH_W:0] sum;
        r = '{p.dst_color, p.dst_z, p.dst_inf, 1'b0};
        if (mode == MODE_TRANSFER) begin
            if (p.src_color[ALPHA_LSB +: CHAN_W] != ALPHA_ZERO && !p.src_inf) begin
                r.changed = 1'b1;
                if (p.dst_inf || $signed(p.src_z) >= $signed(p.dst_z)) begin
                    r.color = blend_over_px(p.src_color, p.dst_color);
                    r.depth = p.src_z;
                    r.inf   = 1'b0;
                end else begin
                    r.color = blend_over_px(p.dst_color, p.src_color);
                end
            end
        end else if (p.src_color[ALPHA_LSB +: CHAN_W] != ALPHA_ZERO && !p.src_inf &&
                     p.dst_color[ALPHA_LSB +: CHAN_W] != ALPHA_ZERO && !p.dst_inf) begin
            sum = $signed({p.src_z[DEPTH_W-1], p.src_z}) +
                  $signed({p.dst_z[DEPTH_W-1], p.dst_z});
            // The two top bits disagree only when the sum left the signed range.
            if (sum[DEPTH_W] != sum[DEPTH_W-1]) begin
                r.depth = sum[DEPTH_W] ? DEPTH_MIN : DEPTH_MAX;
            end else begin
                r.depth = sum[DEPTH_W-1:0];
            end
            r.inf     = 1'b0;
            r.color   = blend_over_px(p.src_color, p.dst_color);
            r.changed = 1'b1;
        end
        return r;
    endfunction

    function automatic bit same_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got === want) begin
            return 1'b1;
        end
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        return 1'b0;
    endfunction

    function automatic logic [COLOR_W-1:0] random_color();
        logic [COLOR_W-1:0] c;
        c = $urandom;
        case ($urandom_range(0, 5))
            0: c[ALPHA_LSB +: CHAN_W] = ALPHA_ZERO;
            1: c[ALPHA_LSB +: CHAN_W] = ALPHA_MAX;
            2: c[ALPHA_LSB +: CHAN_W] = 8'h01;
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [DEPTH_W-1:0] random_depth();
        logic [DEPTH_W-1:0] d;
        d = $urandom;
        case ($urandom_range(0, 7))
            0: d = DEPTH_MAX;
            1: d = DEPTH_MIN;
            2, 3: d = {{16{d[15]}}, d[15:0]};
            default: ;
        endcase
        return d;
    endfunction

    function automatic t_pixel_pair random_pair();
        t_pixel_pair p;
        p.src_color = random_color();
        p.src_z     = random_depth();
        p.src_inf   = ($urandom_range(0, 7) == 0);
        p.dst_color = random_color();
        p.dst_z     = ($urandom_range(0, 7) == 0) ? p.src_z : random_depth();
        p.dst_inf   = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    function automatic void add_row(input t_mode m, input logic [31:0] sc, input logic [31:0] sd,
                                    input logic si, input logic [31:0] dc,
                                    input logic [31:0] dd, input logic di, input logic listed,
                                    input logic [31:0] oc, input logic [31:0] od,
                                    input logic oi, input logic ch);
        t_blend_row row;
        row.mode   = m;
        row.req    = '{sc, sd, si, dc, dd, di};
        row.listed = listed;
        row.want   = '{oc, od, oi, ch};
        directed_rows.push_back(row);
    endfunction

    // Holds the request on the ports until the block takes it.
    task automatic send_px(input t_pixel_pair p, input logic listed, input t_merged_px want);
        listed_q.push_back('{listed, want});
        i_src_color          <= p.src_color;
        i_src_depth          <= p.src_z;
        i_src_depth_infinite <= p.src_inf;
        i_dst_color          <= p.dst_color;
        i_dst_depth          <= p.dst_z;
        i_dst_depth_infinite <= p.dst_inf;
        start                <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (listed_q.size() != 0 || merge_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_mode m);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_merged_px    got;
        t_merged_px    want;
        t_listed_merge entry;
        logic          hit;
        hit = 1'b0;
        if (!i_rst_n) begin
            cfg_mode = MODE_TRANSFER;
        end else begin
            if (o_valid === 1'b1) begin
                hit = 1'b1;
                n_results++;
                got = '{o_out_color, o_out_depth, o_out_depth_infinite, o_pixel_changed};
                if (merge_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual color %h depth %h",
                             $time, got.color, got.depth);
                    n_errors++;
                end else begin
                    want = merge_q.pop_front();
                    if (!(same_field("out_color", want.color, got.color) &
                          same_field("out_depth", want.depth, got.depth) &
                          same_field("out_depth_infinite", 32'(want.inf), 32'(got.inf)) &
                          same_field("pixel_changed", 32'(want.changed), 32'(got.changed))))
                        n_errors++;
                end
            end else if (o_valid !== 1'b0) begin
                $display("%0t: o_valid unknown: expected 0 or 1, actual %b", $time, o_valid);
                n_errors++;
            end
            if (start === 1'b1 && busy === 1'b0 && listed_q.size() != 0) begin
                hit = 1'b1;
                n_accepted++;
                entry = listed_q.pop_front();
                want = entry.listed ? entry.want :
                       predict_merge(cfg_mode, '{i_src_color, i_src_depth, i_src_depth_infinite,
                                                 i_dst_color, i_dst_depth, i_dst_depth_infinite});
                if (!want.changed) n_skipped++;
                merge_q.push_back(want);
            end
            if (i_cfg_we === 1'b1) begin
                cfg_mode = t_mode'(i_cfg_wdata);
            end
        end
        idle_cycles = hit ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog expired with %0d requests and %0d results outstanding",
                     $time, listed_q.size(), merge_q.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        t_mode cur_mode;
        t_mode phase_mode[NUM_PHASES];
        int    phase_idle[NUM_PHASES];
        phase_mode = '{MODE_TRANSFER, MODE_SCULPT, MODE_TRANSFER,
                       MODE_SCULPT, MODE_TRANSFER, MODE_SCULPT};
        phase_idle = '{0, 50, 38, 0, 50, 38};

        // Transfer: skips, each depth order, infinite destination, channel wrap.
        add_row(MODE_TRANSFER, 32'h0011_2233, 32'h0001_0000, 1'b0, 32'h8040_4040,
                32'h0005_0000, 1'b0, 1'b1, 32'h8040_4040, 32'h0005_0000, 1'b0, 1'b0);
        add_row(MODE_TRANSFER, 32'hFF10_2030, 32'h0000_0000, 1'b1, 32'h4020_2020,
                DEPTH_MIN, 1'b1, 1'b1, 32'h4020_2020, DEPTH_MIN, 1'b1, 1'b0);
        add_row(MODE_TRANSFER, 32'hFFA0_B0C0, 32'h0002_0000, 1'b0, 32'h8080_8080,
                32'h0001_0000, 1'b0, 1'b1, 32'hFFA0_B0C0, 32'h0002_0000, 1'b0, 1'b1);
        add_row(MODE_TRANSFER, 32'hFF00_00FF, DEPTH_MIN, 1'b0, 32'h1234_5678,
                32'h0000_0000, 1'b1, 1'b1, 32'hFF00_00FF, DEPTH_MIN, 1'b0, 1'b1);
        add_row(MODE_TRANSFER, 32'h8040_2010, 32'h0003_0000, 1'b0, 32'h6060_6060,
                32'h0003_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(MODE_TRANSFER, 32'h4040_4040, 32'h0001_0000, 1'b0, 32'hFF11_2233,
                32'h0004_0000, 1'b0, 1'b1, 32'hFF11_2233, 32'h0004_0000, 1'b0, 1'b1);
        add_row(MODE_TRANSFER, 32'hC0C0_8040, 32'hFFFF_0000, 1'b0, 32'h4020_1008,
                32'h0000_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(MODE_TRANSFER, 32'h01FF_FFFF, 32'h0000_0001, 1'b0, 32'hFFFF_FFFF,
                32'h0000_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(MODE_TRANSFER, 32'hFFFF_FFFF, DEPTH_MAX, 1'b0, 32'h0000_0000,
                DEPTH_MIN, 1'b0, 1'b1, 32'hFFFF_FFFF, DEPTH_MAX, 1'b0, 1'b1);
        add_row(MODE_TRANSFER, 32'h7F7F_7F7F, DEPTH_MIN, 1'b0, 32'h0000_0000,
                DEPTH_MAX, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(MODE_TRANSFER, 32'h00FF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF,
                DEPTH_MAX, 1'b1, 1'b1, 32'hFFFF_FFFF, DEPTH_MAX, 1'b1, 1'b0);
        add_row(MODE_TRANSFER, 32'h0100_0000, 32'h0000_0000, 1'b0, 32'h0000_0000,
                32'h0000_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        // Sculpt: each skip condition, saturation both ways, ordinary sums.
        add_row(MODE_SCULPT, 32'h00FF_FFFF, 32'h0000_0001, 1'b0, 32'hFF80_8080,
                32'h0000_0002, 1'b0, 1'b1, 32'hFF80_8080, 32'h0000_0002, 1'b0, 1'b0);
        add_row(MODE_SCULPT, 32'hFF80_8080, 32'h0000_0001, 1'b0, 32'h00FF_FFFF,
                32'h0000_0002, 1'b0, 1'b1, 32'h00FF_FFFF, 32'h0000_0002, 1'b0, 1'b0);
        add_row(MODE_SCULPT, 32'hFF80_8080, 32'h0000_0000, 1'b1, 32'h8080_8080,
                32'h0001_0000, 1'b0, 1'b1, 32'h8080_8080, 32'h0001_0000, 1'b0, 1'b0);
        add_row(MODE_SCULPT, 32'hFF80_8080, 32'h0000_0001, 1'b0, 32'h8080_8080,
                32'h0005_0000, 1'b1, 1'b1, 32'h8080_8080, 32'h0005_0000, 1'b1, 1'b0);
        add_row(MODE_SCULPT, 32'hFF12_3456, DEPTH_MAX, 1'b0, 32'hFF65_4321,
                32'h0000_0001, 1'b0, 1'b1, 32'hFF12_3456, DEPTH_MAX, 1'b0, 1'b1);
        add_row(MODE_SCULPT, 32'hFFAB_CDEF, DEPTH_MIN, 1'b0, 32'h8000_0000,
                32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFAB_CDEF, DEPTH_MIN, 1'b0, 1'b1);
        add_row(MODE_SCULPT, 32'h8040_2010, 32'h0001_0000, 1'b0, 32'h8080_8080,
                32'h0002_0000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(MODE_SCULPT, 32'h0101_0101, DEPTH_MAX, 1'b0, 32'hFFFF_FFFF,
                DEPTH_MAX, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(MODE_SCULPT, 32'hFEFE_FEFE, DEPTH_MIN, 1'b0, 32'h0102_0304,
                DEPTH_MIN, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
        add_row(MODE_SCULPT, 32'h4030_2010, 32'hFFFE_8000, 1'b0, 32'hC0C0_C0C0,
                32'h0001_8000, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        cur_mode = MODE_TRANSFER;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].mode != cur_mode) begin
                set_mode(directed_rows[r].mode);
                cur_mode = directed_rows[r].mode;
            end
            if (directed_rows[r].listed) n_listed++;
            send_px(directed_rows[r].req, directed_rows[r].listed, directed_rows[r].want);
        end

        // Random requests; the idle share of each phase that has one lets gaps land on every pipe stage.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_mode(phase_mode[ph]);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                send_px(random_pair(), 1'b0, '0);
                while ($urandom_range(0, 99) < phase_idle[ph]) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                end
            end
        end

        drain();
        $display("Merged %0d pixel requests (%0d with listed results, %0d skipped) in both modes,",
                 n_accepted, n_listed, n_skipped);
        $display("checked %0d results across %0d idle/mode phases after the directed set.",
                 n_results, NUM_PHASES);
        if (n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> depth_merge_premultiplied_blend.f
hdl/dmpb_pkg.sv
hdl/dmpb_decide.sv
hdl/dmpb_blend.sv
hdl/depth_merge_premultiplied_blend.sv
tb/sv/tb_top.sv
